/* src/dsv_pkg.sv */
`default_nettype none

package dsv_pkg;

  // operand width of all arithmetic
  localparam int unsigned OPW   = 32;
  localparam int unsigned CNT_W = $clog2(OPW);
  localparam int unsigned AW    = 5;

  // command codes
  localparam logic CMD_SIGN   = 1'b0;
  localparam logic CMD_VERIFY = 1'b1;

  typedef struct packed {
    logic           cmd;
    logic [OPW-1:0] msg_hash;
    logic [OPW-1:0] nonce_k;
    logic [OPW-1:0] sig_r;
    logic [OPW-1:0] sig_s;
  } in_t;

  typedef struct packed {
    logic [OPW-1:0] out_r;
    logic [OPW-1:0] out_s;
    logic           sig_valid;
    logic           status;
  } out_t;

  typedef struct packed {
    logic [OPW-1:0] modulus_p;
    logic [OPW-1:0] order_q;
    logic [OPW-1:0] generator_g;
    logic [OPW-1:0] signing_key;
    logic [OPW-1:0] verify_key;
  } cfg_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MOV,
    OP_SHL,
    OP_ADDM,
    OP_SUBM,
    OP_DIV,
    OP_MUL,
    OP_INVI,
    OP_ROT
  } op_e;

  // datapath operand / destination selects
  typedef enum logic [4:0] {
    R_ZERO, R_ONE, R_P, R_Q, R_G, R_X, R_Y, R_H, R_K, R_SR, R_SS, R_QT,
    R_ACC, R_BASE, R_EXP, R_R0, R_R1, R_T0, R_T1, R_TMP, R_NT, R_U1, R_U2,
    R_ROUT, R_SOUT
  } reg_e;

  typedef struct packed {
    logic start;
    op_e  op;
    reg_e src_a;
    reg_e src_b;
    reg_e src_m;
    reg_e dst;
    logic load_in;
    logic load_out;
    logic out_verify;
    logic out_fail;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic exp_msb;
    logic r1_zero;
    logic r0_one;
    logic q_lt2;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/dsa_sign_verify_engine.sv */
`default_nettype none

// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-----------------------------
// in       | input     | in_valid_i / in_ready_o  | in_data_i  (dsv_pkg::in_t)
// out      | output    | out_valid_o / out_ready_i| out_data_o (dsv_pkg::out_t)
// cfg      | input     | APB psel/penable/pwrite  | paddr, pwdata, prdata
//
// Each modmul and each division runs on one shared 32-step iterative unit.
// A sign takes one exponentiation plus an inverse built from Euclid steps; a verify
// takes an inverse and two exponentiations. The amount of work depends on the
// operand values.
// One item is in work at a time; the next transfer is taken while a result waits.
// Reset is asynchronous, active low, and restores the default p, q, g, x, y.
module dsa_sign_verify_engine (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire dsv_pkg::in_t            in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output dsv_pkg::out_t                out_data_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [dsv_pkg::AW-1:0]  paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready
);
  import dsv_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  dsv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsv_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* src/dsv_apb_regs.sv */
`default_nettype none

module dsv_apb_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [dsv_pkg::AW-1:0]   paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output dsv_pkg::cfg_t                 cfg_o
);
  import dsv_pkg::*;

  localparam logic [2:0] IDX_P = 3'd0;
  localparam logic [2:0] IDX_Q = 3'd1;
  localparam logic [2:0] IDX_G = 3'd2;
  localparam logic [2:0] IDX_X = 3'd3;
  localparam logic [2:0] IDX_Y = 3'd4;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus_p   <= OPW'(23);
      cfg_q.order_q     <= OPW'(11);
      cfg_q.generator_g <= OPW'(4);
      cfg_q.signing_key <= '0;
      cfg_q.verify_key  <= '0;
    end else if (wr_en) begin
      case (idx)
        IDX_P:   cfg_q.modulus_p   <= pwdata[OPW-1:0];
        IDX_Q:   cfg_q.order_q     <= pwdata[OPW-1:0];
        IDX_G:   cfg_q.generator_g <= pwdata[OPW-1:0];
        IDX_X:   cfg_q.signing_key <= pwdata[OPW-1:0];
        IDX_Y:   cfg_q.verify_key  <= pwdata[OPW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      IDX_P:   prdata = 32'(cfg_q.modulus_p);
      IDX_Q:   prdata = 32'(cfg_q.order_q);
      IDX_G:   prdata = 32'(cfg_q.generator_g);
      IDX_X:   prdata = 32'(cfg_q.signing_key);
      IDX_Y:   prdata = 32'(cfg_q.verify_key);
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/dsv_datapath.sv */
`default_nettype none

module dsv_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dsv_pkg::cfg_t     cfg_i,
  input  wire dsv_pkg::in_t      in_data_i,
  input  wire dsv_pkg::dp_cmd_t  cmd_i,
  output dsv_pkg::dp_stat_t      stat_o,
  output dsv_pkg::out_t          out_data_o
);
  import dsv_pkg::*;

  // working registers
  logic [OPW-1:0] h_q, k_q, sr_q, ss_q, qt_q;
  logic [OPW-1:0] acc_q, base_q, exp_q, r0_q, r1_q, t0_q, t1_q;
  logic [OPW-1:0] tmp_q, nt_q, u1_q, u2_q, rout_q, sout_q;
  out_t           out_q;

  // iterative multiply / divide unit
  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OPW-1:0]   x_q, y_q, m_q, z_q;

  logic [OPW-1:0] opa, opb, opm;
  logic [OPW-1:0] wdata;
  logic           single_op, multi_op, last, wen;

  function automatic logic [OPW-1:0] sel_val(reg_e s);
    logic [OPW-1:0] v;
    case (s)
      R_ZERO:  v = '0;
      R_ONE:   v = OPW'(1);
      R_P:     v = cfg_i.modulus_p;
      R_Q:     v = cfg_i.order_q;
      R_G:     v = cfg_i.generator_g;
      R_X:     v = cfg_i.signing_key;
      R_Y:     v = cfg_i.verify_key;
      R_H:     v = h_q;
      R_K:     v = k_q;
      R_SR:    v = sr_q;
      R_SS:    v = ss_q;
      R_QT:    v = qt_q;
      R_ACC:   v = acc_q;
      R_BASE:  v = base_q;
      R_EXP:   v = exp_q;
      R_R0:    v = r0_q;
      R_R1:    v = r1_q;
      R_T0:    v = t0_q;
      R_T1:    v = t1_q;
      R_TMP:   v = tmp_q;
      R_NT:    v = nt_q;
      R_U1:    v = u1_q;
      R_U2:    v = u2_q;
      R_ROUT:  v = rout_q;
      R_SOUT:  v = sout_q;
      default: v = '0;
    endcase
    return v;
  endfunction

  // operand selects
  always_comb begin
    opa = sel_val(cmd_i.src_a);
    opb = sel_val(cmd_i.src_b);
    opm = sel_val(cmd_i.src_m);
  end

  // one step of the shared unit: MSB-first modmul or restoring division
  logic [OPW:0]   dbl, dbl_r, add, add_r, dv_t, dv_r;
  logic           dv_ge;
  logic [OPW-1:0] z_n, x_n, mres, rem, quo;

  always_comb begin
    dbl   = {z_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add   = {1'b0, dbl_r[OPW-1:0]} + (x_q[OPW-1] ? {1'b0, y_q} : '0);
    add_r = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
    dv_t  = {z_q, x_q[OPW-1]};
    dv_ge = (dv_t >= {1'b0, y_q});
    dv_r  = dv_ge ? dv_t - {1'b0, y_q} : dv_t;
    if (cmd_i.op == OP_MUL) begin
      z_n = add_r[OPW-1:0];
      x_n = {x_q[OPW-2:0], 1'b0};
    end else begin
      z_n = dv_r[OPW-1:0];
      x_n = {x_q[OPW-2:0], dv_ge};
    end
    mres = (m_q == '0) ? '0 : z_n;
    rem  = (y_q == '0) ? '0 : z_n;
    quo  = (y_q == '0) ? '0 : x_n;
  end

  // modular add and subtract, computed combinationally
  logic [OPW:0]   sum;
  logic [OPW-1:0] addm, subm;

  always_comb begin
    sum  = {1'b0, opa} + {1'b0, opb};
    addm = (sum >= {1'b0, opm}) ? OPW'(sum - {1'b0, opm}) : sum[OPW-1:0];
    subm = (opa >= opb) ? opa - opb : opa - opb + opm;
  end

  always_comb begin
    multi_op  = (cmd_i.op == OP_MUL) || (cmd_i.op == OP_DIV);
    single_op = cmd_i.start && !busy_q && !multi_op;
    last      = busy_q && (cnt_q == CNT_W'(OPW-1));
    case (cmd_i.op)
      OP_MOV:  wdata = opa;
      OP_SHL:  wdata = {opa[OPW-2:0], 1'b0};
      OP_ADDM: wdata = addm;
      OP_SUBM: wdata = subm;
      OP_MUL:  wdata = mres;
      OP_DIV:  wdata = rem;
      default: wdata = '0;
    endcase
    wen = last || (single_op && ((cmd_i.op == OP_MOV) || (cmd_i.op == OP_SHL) ||
                                 (cmd_i.op == OP_ADDM) || (cmd_i.op == OP_SUBM)));
  end

  // unit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (last) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.start && multi_op) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end
  end

  // unit operands
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      z_q <= z_n;
      x_q <= x_n;
    end else if (cmd_i.start && multi_op) begin
      z_q <= '0;
      m_q <= opm;
      if (cmd_i.op == OP_MUL) begin
        x_q <= opb;
        y_q <= opa;
      end else begin
        x_q <= opa;
        y_q <= opb;
      end
    end
  end

  // register file writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      h_q  <= in_data_i.msg_hash;
      k_q  <= in_data_i.nonce_k;
      sr_q <= in_data_i.sig_r;
      ss_q <= in_data_i.sig_s;
    end
    if (last && (cmd_i.op == OP_DIV)) begin
      qt_q <= quo;
    end
    if (single_op && (cmd_i.op == OP_INVI)) begin
      r0_q <= cfg_i.order_q;
      t0_q <= '0;
      t1_q <= OPW'(1);
    end
    if (single_op && (cmd_i.op == OP_ROT)) begin
      r0_q <= r1_q;
      r1_q <= tmp_q;
      t0_q <= t1_q;
      t1_q <= nt_q;
    end
    if (wen) begin
      case (cmd_i.dst)
        R_ACC:   acc_q  <= wdata;
        R_BASE:  base_q <= wdata;
        R_EXP:   exp_q  <= wdata;
        R_R1:    r1_q   <= wdata;
        R_TMP:   tmp_q  <= wdata;
        R_NT:    nt_q   <= wdata;
        R_U1:    u1_q   <= wdata;
        R_U2:    u2_q   <= wdata;
        R_ROUT:  rout_q <= wdata;
        R_SOUT:  sout_q <= wdata;
        default: ;
      endcase
    end
  end

  // result register
  logic range_ok, v_eq;

  assign range_ok = (sr_q != '0) && (sr_q < cfg_i.order_q) &&
                    (ss_q != '0) && (ss_q < cfg_i.order_q);
  assign v_eq     = (tmp_q == sr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_r     <= cmd_i.out_verify ? '0 : rout_q;
      out_q.out_s     <= (cmd_i.out_verify || cmd_i.out_fail) ? '0 : sout_q;
      out_q.sig_valid <= cmd_i.out_verify && !cmd_i.out_fail && range_ok && v_eq;
      out_q.status    <= cmd_i.out_fail;
    end
  end

  assign out_data_o     = out_q;
  assign stat_o.done    = single_op || last;
  assign stat_o.exp_msb = exp_q[OPW-1];
  assign stat_o.r1_zero = (r1_q == '0);
  assign stat_o.r0_one  = (r0_q == OPW'(1));
  assign stat_o.q_lt2   = (cfg_i.order_q < OPW'(2));

endmodule

`default_nettype wire

/* src/dsv_ctrl.sv */
`default_nettype none

module dsv_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_cmd_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire dsv_pkg::dp_stat_t  stat_i,
  output dsv_pkg::dp_cmd_t        cmd_o
);
  import dsv_pkg::*;

  typedef enum logic [27:0] {
    ST_IDLE    = 28'd1 << 0,
    ST_POW_B   = 28'd1 << 1,
    ST_POW_A   = 28'd1 << 2,
    ST_POW_E   = 28'd1 << 3,
    ST_POW_SQ  = 28'd1 << 4,
    ST_POW_ML  = 28'd1 << 5,
    ST_POW_SH  = 28'd1 << 6,
    ST_SG_R    = 28'd1 << 7,
    ST_INV_R1  = 28'd1 << 8,
    ST_INV_SET = 28'd1 << 9,
    ST_INV_LP  = 28'd1 << 10,
    ST_INV_QM  = 28'd1 << 11,
    ST_INV_MU  = 28'd1 << 12,
    ST_INV_SB  = 28'd1 << 13,
    ST_INV_RT  = 28'd1 << 14,
    ST_SG_X    = 28'd1 << 15,
    ST_SG_XR   = 28'd1 << 16,
    ST_SG_H    = 28'd1 << 17,
    ST_SG_ADD  = 28'd1 << 18,
    ST_SG_S    = 28'd1 << 19,
    ST_VF_U1   = 28'd1 << 20,
    ST_VF_U1M  = 28'd1 << 21,
    ST_VF_U2   = 28'd1 << 22,
    ST_VF_U2M  = 28'd1 << 23,
    ST_VF_SV   = 28'd1 << 24,
    ST_VF_V    = 28'd1 << 25,
    ST_VF_VQ   = 28'd1 << 26,
    ST_DONE    = 28'd1 << 27
  } state_e;

  // which exponentiation is running
  typedef enum logic [1:0] {
    PC_SIGN,
    PC_V1,
    PC_V2
  } pow_ctx_e;

  state_e           state_q, state_d;
  pow_ctx_e         ctx_q, ctx_d;
  logic             verify_q, verify_d;
  logic             fail_q, fail_d;
  logic [CNT_W-1:0] bit_q, bit_d;
  logic             out_valid_q, out_valid_d;

  dp_cmd_t cmd;

  function automatic dp_cmd_t mk(dp_cmd_t c, op_e op, reg_e a, reg_e b, reg_e m, reg_e d);
    dp_cmd_t r;
    r       = c;
    r.start = 1'b1;
    r.op    = op;
    r.src_a = a;
    r.src_b = b;
    r.src_m = m;
    r.dst   = d;
    return r;
  endfunction

  // sequencer
  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    verify_d    = verify_q;
    fail_d      = fail_q;
    bit_d       = bit_q;
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.src_a   = R_ZERO;
    cmd.src_b   = R_ZERO;
    cmd.src_m   = R_ZERO;
    cmd.dst     = R_ZERO;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          verify_d    = (in_cmd_i == CMD_VERIFY);
          fail_d      = 1'b0;
          ctx_d       = PC_SIGN;
          state_d     = (in_cmd_i == CMD_VERIFY) ? ST_INV_R1 : ST_POW_B;
        end
      end
      ST_POW_B: begin
        cmd = mk(cmd, OP_DIV, (ctx_q == PC_V2) ? R_Y : R_G, R_P, R_ZERO, R_BASE);
        if (stat_i.done) state_d = ST_POW_A;
      end
      ST_POW_A: begin
        cmd = mk(cmd, OP_DIV, R_ONE, R_P, R_ZERO, R_ACC);
        if (stat_i.done) state_d = ST_POW_E;
      end
      ST_POW_E: begin
        cmd = mk(cmd, OP_MOV, (ctx_q == PC_SIGN) ? R_K : ((ctx_q == PC_V1) ? R_U1 : R_U2),
                 R_ZERO, R_ZERO, R_EXP);
        bit_d = '0;
        if (stat_i.done) state_d = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        cmd = mk(cmd, OP_MUL, R_ACC, R_ACC, R_P, R_ACC);
        if (stat_i.done) state_d = stat_i.exp_msb ? ST_POW_ML : ST_POW_SH;
      end
      ST_POW_ML: begin
        cmd = mk(cmd, OP_MUL, R_ACC, R_BASE, R_P, R_ACC);
        if (stat_i.done) state_d = ST_POW_SH;
      end
      ST_POW_SH: begin
        cmd = mk(cmd, OP_SHL, R_EXP, R_ZERO, R_ZERO, R_EXP);
        if (stat_i.done) begin
          bit_d = bit_q + CNT_W'(1);
          if (bit_q == CNT_W'(OPW-1)) begin
            case (ctx_q)
              PC_SIGN: state_d = ST_SG_R;
              PC_V1:   state_d = ST_VF_SV;
              default: state_d = ST_VF_V;
            endcase
          end else begin
            state_d = ST_POW_SQ;
          end
        end
      end
      ST_SG_R: begin
        cmd = mk(cmd, OP_DIV, R_ACC, R_Q, R_ZERO, R_ROUT);
        if (stat_i.done) state_d = ST_INV_R1;
      end
      ST_INV_R1: begin
        if (stat_i.q_lt2) begin
          fail_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd = mk(cmd, OP_DIV, verify_q ? R_SS : R_K, R_Q, R_ZERO, R_R1);
          if (stat_i.done) state_d = ST_INV_SET;
        end
      end
      ST_INV_SET: begin
        cmd = mk(cmd, OP_INVI, R_ZERO, R_ZERO, R_ZERO, R_ZERO);
        if (stat_i.done) state_d = ST_INV_LP;
      end
      ST_INV_LP: begin
        if (stat_i.r1_zero) begin
          if (!stat_i.r0_one) begin
            fail_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = verify_q ? ST_VF_U1 : ST_SG_X;
          end
        end else begin
          cmd = mk(cmd, OP_DIV, R_R0, R_R1, R_ZERO, R_TMP);
          if (stat_i.done) state_d = ST_INV_QM;
        end
      end
      ST_INV_QM: begin
        cmd = mk(cmd, OP_DIV, R_QT, R_Q, R_ZERO, R_NT);
        if (stat_i.done) state_d = ST_INV_MU;
      end
      ST_INV_MU: begin
        cmd = mk(cmd, OP_MUL, R_NT, R_T1, R_Q, R_NT);
        if (stat_i.done) state_d = ST_INV_SB;
      end
      ST_INV_SB: begin
        cmd = mk(cmd, OP_SUBM, R_T0, R_NT, R_Q, R_NT);
        if (stat_i.done) state_d = ST_INV_RT;
      end
      ST_INV_RT: begin
        cmd = mk(cmd, OP_ROT, R_ZERO, R_ZERO, R_ZERO, R_ZERO);
        if (stat_i.done) state_d = ST_INV_LP;
      end
      ST_SG_X: begin
        cmd = mk(cmd, OP_DIV, R_X, R_Q, R_ZERO, R_TMP);
        if (stat_i.done) state_d = ST_SG_XR;
      end
      ST_SG_XR: begin
        cmd = mk(cmd, OP_MUL, R_TMP, R_ROUT, R_Q, R_TMP);
        if (stat_i.done) state_d = ST_SG_H;
      end
      ST_SG_H: begin
        cmd = mk(cmd, OP_DIV, R_H, R_Q, R_ZERO, R_U1);
        if (stat_i.done) state_d = ST_SG_ADD;
      end
      ST_SG_ADD: begin
        cmd = mk(cmd, OP_ADDM, R_U1, R_TMP, R_Q, R_U1);
        if (stat_i.done) state_d = ST_SG_S;
      end
      ST_SG_S: begin
        cmd = mk(cmd, OP_MUL, R_T0, R_U1, R_Q, R_SOUT);
        if (stat_i.done) state_d = ST_DONE;
      end
      ST_VF_U1: begin
        cmd = mk(cmd, OP_DIV, R_H, R_Q, R_ZERO, R_U1);
        if (stat_i.done) state_d = ST_VF_U1M;
      end
      ST_VF_U1M: begin
        cmd = mk(cmd, OP_MUL, R_U1, R_T0, R_Q, R_U1);
        if (stat_i.done) state_d = ST_VF_U2;
      end
      ST_VF_U2: begin
        cmd = mk(cmd, OP_DIV, R_SR, R_Q, R_ZERO, R_U2);
        if (stat_i.done) state_d = ST_VF_U2M;
      end
      ST_VF_U2M: begin
        cmd = mk(cmd, OP_MUL, R_U2, R_T0, R_Q, R_U2);
        if (stat_i.done) begin
          ctx_d   = PC_V1;
          state_d = ST_POW_B;
        end
      end
      ST_VF_SV: begin
        cmd = mk(cmd, OP_MOV, R_ACC, R_ZERO, R_ZERO, R_U1);
        if (stat_i.done) begin
          ctx_d   = PC_V2;
          state_d = ST_POW_B;
        end
      end
      ST_VF_V: begin
        cmd = mk(cmd, OP_MUL, R_U1, R_ACC, R_P, R_TMP);
        if (stat_i.done) state_d = ST_VF_VQ;
      end
      ST_VF_VQ: begin
        cmd = mk(cmd, OP_DIV, R_TMP, R_Q, R_ZERO, R_TMP);
        if (stat_i.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out   = 1'b1;
          cmd.out_verify = verify_q;
          cmd.out_fail   = fail_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctx_q       <= PC_SIGN;
      verify_q    <= 1'b0;
      fail_q      <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      verify_q    <= verify_d;
      fail_q      <= fail_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  // checks
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  a_done_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.done |-> cmd.start)
    else $error("datapath done without an issued op");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.load_out))
    else $error("output valid without a result load");

endmodule

`default_nettype wire

/* tb/sv/dsv_checker.sv */
module dsv_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  wire dsv_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_ready_i,
  input  wire dsv_pkg::out_t out_data_i,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [dsv_pkg::AW-1:0] paddr,
  input  wire logic [31:0]   pwdata,
  input  wire logic          pready,
  output int                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsv_pkg::*;

  typedef logic [63:0] u64_t;

  // shadow copy of the key and group registers
  u64_t mod_p, ord_q, gen_g, key_x, key_y;
  out_t pending_sigs[$];

  function automatic u64_t red_mod(u64_t a, u64_t m);
    return (m == 0) ? 64'd0 : a % m;
  endfunction

  function automatic u64_t add_mod(u64_t a, u64_t b, u64_t m);
    u64_t gap;
    gap = m - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic u64_t mul_mod(u64_t a, u64_t b, u64_t m);
    u64_t acc;
    acc = 0;
    if (m == 0) return 0;
    a = a % m;
    b = b % m;
    while (b != 0) begin
      if (b[0]) acc = add_mod(acc, a, m);
      a = add_mod(a, a, m);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic u64_t pow_mod(u64_t base, u64_t e, u64_t m);
    u64_t acc;
    acc = red_mod(1, m);
    base = red_mod(base, m);
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, base, m);
      base = mul_mod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // extended Euclid; returns 0 when a has no inverse mod m
  function automatic bit inv_mod(u64_t a, u64_t m, output u64_t inv);
    u64_t r0, r1, t0, t1, qt, nr, nt;
    inv = 0;
    if (m < 2) return 0;
    r0 = m;
    r1 = a % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      nr = r0 - qt * r1;
      nt = mul_mod(qt, t1, m);
      nt = add_mod(t0, (nt == 0) ? 64'd0 : m - nt, m);
      r0 = r1; r1 = nr;
      t0 = t1; t1 = nt;
    end
    if (r0 != 1) return 0;
    inv = t0;
    return 1;
  endfunction

  function automatic out_t predict_signature(in_t it);
    out_t res;
    u64_t h, k, kinv, t, r, s, w, u1, u2, v;
    res = '0;
    h = 64'(it.msg_hash);
    if (it.cmd == CMD_SIGN) begin
      k = 64'(it.nonce_k);
      r = red_mod(pow_mod(gen_g, k, mod_p), ord_q);
      res.out_r = r[31:0];
      if (inv_mod(k, ord_q, kinv)) begin
        t = add_mod(red_mod(h, ord_q), mul_mod(key_x, r, ord_q), ord_q);
        s = mul_mod(kinv, t, ord_q);
        res.out_s = s[31:0];
      end else begin
        res.status = 1'b1;
      end
    end else begin
      r = 64'(it.sig_r);
      s = 64'(it.sig_s);
      if (inv_mod(s, ord_q, w)) begin
        u1 = mul_mod(h, w, ord_q);
        u2 = mul_mod(r, w, ord_q);
        v = red_mod(mul_mod(pow_mod(gen_g, u1, mod_p), pow_mod(key_y, u2, mod_p), mod_p),
                    ord_q);
        res.sig_valid = (r != 0 && r < ord_q && s != 0 && s < ord_q && v == r);
      end else begin
        res.status = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // register writes, input transfers and result checks
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      mod_p <= 23; ord_q <= 11; gen_g <= 4; key_x <= 0; key_y <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 2)
          0: mod_p <= 64'(pwdata);
          1: ord_q <= 64'(pwdata);
          2: gen_g <= 64'(pwdata);
          3: key_x <= 64'(pwdata);
          4: key_y <= 64'(pwdata);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) pending_sigs.push_back(predict_signature(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_sigs.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = pending_sigs.pop_front();
          if (out_data_i.out_r !== want.out_r)
            report_mismatch("out_r", out_data_i.out_r, want.out_r);
          if (out_data_i.out_s !== want.out_s)
            report_mismatch("out_s", out_data_i.out_s, want.out_s);
          if (out_data_i.sig_valid !== want.sig_valid)
            report_mismatch("sig_valid", 32'(out_data_i.sig_valid), 32'(want.sig_valid));
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
        end
      end
    end
  end

  function automatic int pending_count();
    return pending_sigs.size();
  endfunction
endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsv_pkg::*;

  localparam int unsigned REG_P = 0;
  localparam int unsigned REG_Q = 1;
  localparam int unsigned REG_G = 2;
  localparam int unsigned REG_X = 3;
  localparam int unsigned REG_Y = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int out_gap = 0;

  // group settings: p, q, g, x, y
  logic [31:0] set_p, set_q, set_g, set_x, set_y;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dsa_sign_verify_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o,
    .out_ready_i, .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  dsv_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 4);
  endfunction

  task automatic cfg_write(int unsigned idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_group(logic [31:0] p, q, g, x, y);
    set_p = p; set_q = q; set_g = g; set_x = x; set_y = y;
    cfg_write(REG_P, p); cfg_write(REG_Q, q); cfg_write(REG_G, g);
    cfg_write(REG_X, x); cfg_write(REG_Y, y);
  endtask

  // valid drops only when a gap follows the previous transfer
  task automatic send_cmd(in_t it);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic in_t rand_cmd();
    in_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.msg_hash = $urandom;
    it.nonce_k = $urandom;
    it.sig_r = $urandom;
    it.sig_s = $urandom;
    // keep most signatures within range so the equality test decides the verify result
    if ($urandom_range(0, 3) != 0 && set_q > 1) begin
      it.sig_r = $urandom_range(1, set_q - 1);
      it.sig_s = $urandom_range(1, set_q - 1);
    end
    if ($urandom_range(0, 9) == 0) it.nonce_k = set_q * $urandom_range(0, 3);
    return it;
  endfunction

  function automatic in_t mk(logic c, logic [31:0] h, k, r, s);
    in_t it;
    it.cmd = c; it.msg_hash = h; it.nonce_k = k; it.sig_r = r; it.sig_s = s;
    return it;
  endfunction

  // wait for every result, then some slack for a trailing computation
  task automatic drain();
    in_valid_i <= 1'b0;
    while (checker_u.pending_count() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // receiver stalls, mostly short with a few long ones
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_gap = gap_len();
      out_ready_i <= (out_gap == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    in_t it;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_p = 23; set_q = 11; set_g = 4; set_x = 0; set_y = 0;

    // directed: reset group, extremes, non-invertible k and s, out-of-range signature
    send_cmd(mk(CMD_SIGN, 32'd5, 32'd3, 0, 0));
    send_cmd(mk(CMD_SIGN, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
    send_cmd(mk(CMD_SIGN, 32'd0, 32'd0, 0, 0));
    send_cmd(mk(CMD_SIGN, 32'd1, 32'd22, 0, 0));
    send_cmd(mk(CMD_VERIFY, 32'd5, 0, 32'd3, 32'd0));
    send_cmd(mk(CMD_VERIFY, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_cmd(mk(CMD_VERIFY, 32'd5, 0, 32'd14, 32'd3));
    drain();
    // textbook group p=23 q=11 g=4 x=3 y=64 mod 23=18
    load_group(23, 11, 4, 3, 18);
    send_cmd(mk(CMD_SIGN, 32'd7, 32'd5, 0, 0));
    send_cmd(mk(CMD_VERIFY, 32'd7, 0, 32'd1, 32'd4));
    send_cmd(mk(CMD_VERIFY, 32'd7, 0, 32'd1, 32'd15));
    drain();
    // degenerate moduli
    load_group(0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_cmd(mk(CMD_SIGN, 32'd9, 32'd4, 0, 0));
    send_cmd(mk(CMD_VERIFY, 32'd9, 0, 32'd1, 32'd1));
    drain();
    load_group(1, 1, 1, 0, 1);
    send_cmd(mk(CMD_SIGN, 32'd9, 32'd0, 0, 0));
    send_cmd(mk(CMD_VERIFY, 32'd9, 0, 32'd0, 32'd1));
    drain();
    load_group(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'h12345678);
    send_cmd(mk(CMD_SIGN, 32'hFFFFFFFF, 32'hFFFFFFFE, 0, 0));
    send_cmd(mk(CMD_VERIFY, 32'hFFFFFFFF, 0, 32'hFFFFFFFE, 32'hFFFFFFFE));
    drain();

    // random phases over several groups, small and full-width
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_group(23, 11, 4, $urandom_range(0, 10), $urandom_range(0, 22));
        1: load_group(283, 47, 60, $urandom_range(0, 46), $urandom);
        2: load_group(32'd2147483647, 32'd65521, $urandom, $urandom, $urandom);
        3: load_group($urandom, $urandom, $urandom, $urandom, $urandom);
        4: load_group($urandom_range(0, 40), $urandom_range(0, 12), $urandom_range(0, 9),
                      $urandom_range(0, 9), $urandom_range(0, 9));
        default: load_group(32'hFFFFFFFB, 32'hFFFFFFF1, 32'h80000001, $urandom, $urandom);
      endcase
      for (int n = 0; n < 50; n++) begin
        it = rand_cmd();
        send_cmd(it);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("[dsa_sign_verify_engine] OK");
    end else begin
      $display("[dsa_sign_verify_engine] ERROR");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("[dsa_sign_verify_engine] ERROR");
    $finish;
  end
endmodule
